// ===== src/rtip_pkg.sv =====
`timescale 1ns / 1ps

package rtip_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned BaseW   = 6;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned StatusW = 2;
  // product of the 64-bit accumulator and a 7-bit signed radix
  localparam int unsigned ProdW   = ValueW + BaseW + 1;

  localparam logic [BaseW-1:0] BaseReset = BaseW'(10);
  localparam logic [BaseW-1:0] BaseMin   = BaseW'(2);
  localparam logic [BaseW-1:0] BaseMax   = BaseW'(36);

  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7A;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;

  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusFormat   = 2'd1;
  localparam logic [StatusW-1:0] StatusOverflow = 2'd2;

  // negative limits, sign-extended to the product width
  localparam logic signed [ProdW-1:0] LimitNeg =
    {{(ProdW-ValueW){1'b1}}, 1'b1, {(ValueW-1){1'b0}}};
  localparam logic signed [ProdW-1:0] LimitPos =
    {{(ProdW-ValueW){1'b1}}, 1'b1, {(ValueW-2){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_full;
  } dp_stat_t;

endpackage

// ===== src/rtip_ctrl.sv =====
`timescale 1ns / 1ps

module rtip_ctrl
  import rtip_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = stat.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // wait for the output register to free up
        if (!stat.out_full) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_load_to_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_MUL))
    else $error("accepted beat did not start the multiply step");

  a_mul_to_upd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |=> (state == ST_UPD))
    else $error("multiply step not followed by update");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && stat.out_full) |=> (state == ST_EMIT))
    else $error("result dropped while output register full");

endmodule

// ===== src/rtip_dpath.sv =====
`timescale 1ns / 1ps

module rtip_dpath
  import rtip_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [BaseW-1:0]         cfg_wr_data,
  input  logic [CharW-1:0]         char_code,
  input  logic                     last_char,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ValueW-1:0] parsed_value,
  output logic [StatusW-1:0]       parse_status
);

  logic [BaseW-1:0]         number_base;
  logic [CharW-1:0]         char_r;
  logic                     last_r;
  logic signed [ValueW-1:0] acc;
  logic                     minus_seen;
  logic                     at_start;
  logic [StatusW-1:0]       err;
  logic signed [ProdW-1:0]  prod;
  logic [BaseW-1:0]         digit;
  logic                     digit_ok;

  logic [BaseW-1:0]         radix;
  logic [CharW-1:0]         raw_digit;
  logic                     is_alnum;
  logic signed [ProdW-1:0]  diff;
  logic signed [ProdW-1:0]  limit;
  logic signed [ValueW-1:0] value_out;

  always_comb begin
    if (number_base < BaseMin) begin
      radix = BaseMin;
    end else if (number_base > BaseMax) begin
      radix = BaseMax;
    end else begin
      radix = number_base;
    end
  end

  always_comb begin
    raw_digit = '0;
    is_alnum  = 1'b1;
    if (char_r >= ChZero && char_r <= ChNine) begin
      raw_digit = char_r - ChZero;
    end else if (char_r >= ChLowA && char_r <= ChLowZ) begin
      raw_digit = char_r - ChLowA + CharW'(10);
    end else if (char_r >= ChUpA && char_r <= ChUpZ) begin
      raw_digit = char_r - ChUpA + CharW'(10);
    end else begin
      is_alnum = 1'b0;
    end
  end

  // acc*radix - d < limit covers both the pre-multiply and post-multiply checks
  assign limit = minus_seen ? LimitNeg : LimitPos;
  assign diff  = prod - $signed({{(ProdW-BaseW){1'b0}}, digit});

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BaseReset;
    end else if (cfg_wr_en) begin
      number_base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= char_code;
      last_r <= last_char;
    end
    if (cmd.mul) begin
      prod     <= acc * $signed({1'b0, radix});
      digit    <= raw_digit[BaseW-1:0];
      digit_ok <= is_alnum && (raw_digit < {{(CharW-BaseW){1'b0}}, radix});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      minus_seen <= 1'b0;
      at_start   <= 1'b1;
      err        <= StatusOk;
    end else if (cmd.emit) begin
      acc        <= '0;
      minus_seen <= 1'b0;
      at_start   <= 1'b1;
      err        <= StatusOk;
    end else if (cmd.upd && err == StatusOk) begin
      at_start <= 1'b0;
      if (at_start && char_r < ChZero) begin
        if (char_r == ChMinus) begin
          minus_seen <= 1'b1;
          if (last_r) begin
            err <= StatusFormat;
          end
        end else if (char_r != ChPlus || last_r) begin
          err <= StatusFormat;
        end
      end else if (!digit_ok) begin
        err <= StatusFormat;
      end else if (diff < limit) begin
        err <= StatusOverflow;
      end else begin
        acc <= diff[ValueW-1:0];
      end
    end
  end

  assign value_out = minus_seen ? acc : -acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      parse_status <= err;
      parsed_value <= (err == StatusOk) ? value_out : '0;
    end
  end

  assign stat.last     = last_r;
  assign stat.out_full = out_valid && out_stall;

  a_err_zero_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && parse_status != StatusOk) |-> (parsed_value == '0))
    else $error("failed parse carries a nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (parse_status == StatusOk || parse_status == StatusFormat ||
                   parse_status == StatusOverflow))
    else $error("undefined status code on output");

  // accumulator holds the value negated, so it never goes above zero
  a_acc_sign: assert property (@(posedge clk) disable iff (rst)
    acc[ValueW-1] || acc == '0)
    else $error("accumulator went positive");

endmodule

// ===== src/radix_text_to_int64_parser.sv =====
`timescale 1ns / 1ps

// Parses a signed 64-bit integer from text, one ASCII character per input beat,
// with last_char marking the final character. An optional leading '+' or '-' is
// taken; digits are 0-9 and a-z/A-Z below the radix in number_base (2..36,
// out-of-range values clamp). Each character passes through capture, multiply
// by radix, and compare and update of the accumulator, using the 64x7
// multiply followed by a 71-bit subtract and compare; in_stall is high
// while a character is in flight. After the last character an emit step loads
// the output register, waiting while that register is still stalled. One result
// beat per string: the value and status 0 ok, 1 format error, 2 overflow;
// the value is zero unless ok. After an error later characters are ignored
// until the last one. number_base may be written only while the block is idle.
module radix_text_to_int64_parser
  import rtip_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [BaseW-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CharW-1:0]         char_code,
  input  logic                     last_char,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ValueW-1:0] parsed_value,
  output logic [StatusW-1:0]       parse_status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rtip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtip_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .char_code    (char_code),
    .last_char    (last_char),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .parsed_value (parsed_value),
    .parse_status (parse_status)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rtip_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int PhaseChars = 88;

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic [StatusW-1:0]       status;
  } parse_result_t;

  // Mirrors the parser: negative accumulation against the signed limit.
  class parse_scoreboard;
    logic [BaseW-1:0]     base_reg;
    longint               acc;
    bit                   negative;
    bit                   at_start;
    logic [StatusW-1:0]   err;
    parse_result_t        awaited[$];
    int                   mismatches;

    function new();
      base_reg = BaseReset;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      acc = 0;
      negative = 1'b0;
      at_start = 1'b1;
      err = StatusOk;
    endfunction

    function void set_base(logic [BaseW-1:0] v);
      base_reg = v;
    endfunction

    function longint radix();
      if (base_reg < BaseMin) return longint'(BaseMin);
      if (base_reg > BaseMax) return longint'(BaseMax);
      return longint'(base_reg);
    endfunction

    // -1 when the character is no digit of the radix
    function longint digit_of(logic [CharW-1:0] c, longint rdx);
      longint d;
      if (c >= ChZero && c <= ChNine) d = longint'(c - ChZero);
      else if (c >= ChLowA && c <= ChLowZ) d = longint'(c - ChLowA) + 10;
      else if (c >= ChUpA && c <= ChUpZ) d = longint'(c - ChUpA) + 10;
      else return -1;
      return (d < rdx) ? d : -1;
    endfunction

    function void fold_digit(logic [CharW-1:0] c);
      longint rdx;
      longint lim;
      longint multmin;
      longint d;
      rdx = radix();
      lim = 64'h8000_0000_0000_0000;
      if (!negative) lim = lim + 1;
      multmin = lim / rdx;
      d = digit_of(c, rdx);
      if (d < 0) begin
        err = StatusFormat;
        return;
      end
      if (acc < multmin) begin
        err = StatusOverflow;
        return;
      end
      acc = acc * rdx;
      if (acc < lim + d) begin
        err = StatusOverflow;
        return;
      end
      acc = acc - d;
    endfunction

    function void note_char(logic [CharW-1:0] c, logic last);
      parse_result_t r;
      if (err == StatusOk) begin
        if (at_start) begin
          at_start = 1'b0;
          if (c < ChZero) begin
            if (c == ChMinus) negative = 1'b1;
            else if (c != ChPlus) err = StatusFormat;
            if (err == StatusOk && last) err = StatusFormat;
          end else begin
            fold_digit(c);
          end
        end else begin
          fold_digit(c);
        end
      end
      if (!last) return;
      if (err == StatusOk) begin
        r.value = negative ? acc : -acc;
        r.status = StatusOk;
      end else begin
        r.value = '0;
        r.status = err;
      end
      awaited.push_back(r);
      clear();
    endfunction

    function void check_result(logic signed [ValueW-1:0] value, logic [StatusW-1:0] status);
      parse_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat: value %0d status %0d", $time, value, status);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (value !== want.value) begin
        $display("%0t: parsed_value expected %0d, got %0d", $time, want.value, value);
        mismatches++;
      end
      if (status !== want.status) begin
        $display("%0t: parse_status expected %0d, got %0d", $time, want.status, status);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [BaseW-1:0]         cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CharW-1:0]         char_code = '0;
  logic                     last_char = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ValueW-1:0] parsed_value;
  logic [StatusW-1:0]       parse_status;

  parse_scoreboard sb = new();

  int   cycle_count = 0;
  int   chars_sent = 0;
  int   cur_radix = 10;
  bit   calm = 1'b0;
  int   stall_run = 0;
  logic stall_level = 1'b0;
  int   stall_pick;

  radix_text_to_int64_parser dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .last_char    (last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .parsed_value (parsed_value),
    .parse_status (parse_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && !out_stall) sb.check_result(parsed_value, parse_status);
      if (in_valid && in_stall === 1'b0) sb.note_char(char_code, last_char);
    end
  end

  // receiver back-pressure: mostly open, short stalls, rare long ones
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        stall_level = 1'b0;
        stall_run = $urandom_range(1, 20);
      end else if (stall_pick < 92) begin
        stall_level = 1'b1;
        stall_run = $urandom_range(1, 3);
      end else begin
        stall_level = 1'b1;
        stall_run = $urandom_range(10, 40);
      end
    end
    stall_run--;
    out_stall <= calm ? 1'b0 : stall_level;
  end

  function automatic int pick_gap();
    int k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 65) return 0;
    if (k < 88) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CharW-1:0] digit_char(int d);
    if (d < 10) return ChZero + CharW'(d);
    return $urandom_range(0, 1) ? ChLowA + CharW'(d - 10) : ChUpA + CharW'(d - 10);
  endfunction

  function automatic void spell_number(input logic [79:0] mag, input int rdx,
                                       ref logic [CharW-1:0] txt[$]);
    logic [CharW-1:0] digits[$];
    logic [79:0]      rest;
    rest = mag;
    do begin
      digits.push_front(digit_char(int'(rest % 80'(rdx))));
      rest = rest / 80'(rdx);
    end while (rest != 0);
    foreach (digits[i]) txt.push_back(digits[i]);
  endfunction

  // small values mostly, plus magnitudes around 2^63 and 2^64
  function automatic logic [79:0] pick_magnitude();
    logic [79:0] top63;
    int          k;
    top63 = 80'h8000_0000_0000_0000;
    k = $urandom_range(0, 99);
    if (k < 45) return 80'($urandom_range(0, 2000));
    if (k < 70) return 80'({$urandom, $urandom} >> $urandom_range(0, 63));
    case ($urandom_range(0, 5))
      0: return top63 - 1;
      1: return top63;
      2: return top63 + 1;
      3: return top63 - 80'($urandom_range(2, 50));
      4: return top63 + 80'($urandom_range(2, 50));
      default: return 80'hFFFF_FFFF_FFFF_FFFF + 80'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic void make_case(ref logic [CharW-1:0] txt[$]);
    int kind;
    int sign;
    int pos;
    txt.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 5)) txt.push_back(CharW'($urandom_range(0, 255)));
      return;
    end
    sign = $urandom_range(0, 2);
    if (sign == 1) txt.push_back(ChPlus);
    else if (sign == 2) txt.push_back(ChMinus);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) txt.push_back(ChZero);
    spell_number(pick_magnitude(), cur_radix, txt);
    if (kind < 32) begin
      pos = $urandom_range(0, txt.size() - 1);
      case ($urandom_range(0, 3))
        0: txt[pos] = ChMinus;
        1: txt[pos] = ChPlus;
        2: while (txt.size() > 1) void'(txt.pop_back());
        default: txt[pos] = CharW'($urandom_range(0, 255));
      endcase
    end
  endfunction

  // called at a falling edge; returns at the falling edge after the last beat
  task automatic send_text(input logic [CharW-1:0] txt[$]);
    int gap;
    foreach (txt[i]) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      char_code <= txt[i];
      last_char <= (i == txt.size() - 1);
      do @(posedge clk); while (in_stall !== 1'b0);
      chars_sent++;
      @(negedge clk);
    end
  endtask

  task automatic send_literal(input string s);
    logic [CharW-1:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(CharW'(s[i]));
    send_text(txt);
  endtask

  // sender holds off until every result is back, then the pipe empties
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_base(input logic [BaseW-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    sb.set_base(v);
    if (v < BaseMin) cur_radix = int'(BaseMin);
    else if (v > BaseMax) cur_radix = int'(BaseMax);
    else cur_radix = int'(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  logic [BaseW-1:0] base_plan[10];
  logic [CharW-1:0] text_buf[$];
  int               phase_start;

  initial begin
    base_plan = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd1, 6'd37, 6'd16, 6'd8, 6'd10, 6'd10};
    base_plan[8] = BaseW'($urandom_range(2, 36));
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed strings at the reset radix
    send_literal("+");
    send_literal("-");
    send_literal("*");
    send_literal("0");
    send_literal("-0");
    send_literal("+9");
    send_literal("1a");
    send_literal("+-");
    send_literal("5x7");
    send_text('{8'hFF});
    send_text('{8'h00});
    send_literal("z");

    for (int p = 0; p < 10; p++) begin
      settle();
      write_base(base_plan[p]);
      calm = (p % 4 == 3);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PhaseChars) begin
        make_case(text_buf);
        send_text(text_buf);
      end
    end

    calm = 1'b0;
    settle();
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
